// ----- sv/single_source_shortest_paths_defines.svh -----
// assertion macros for the shortest path block
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSP_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SSP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- sv/ssp_pkg.sv -----
// shared constants and types of the shortest path block
`timescale 1ns / 1ps
package ssp_pkg;
	localparam int NODE_W = 7;
	localparam int DIST_W = 22;
	localparam int WEIGHT_IN_W = 16;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

	typedef struct packed {
		logic [DIST_W-1:0] base;
		logic [DIST_W-1:0] addend;
		logic [DIST_W-1:0] bound;
	} alu_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] sum;
		logic lt;
	} alu_rsp_t;
endpackage

// ----- sv/ssp_ram.sv -----
// single port write, registered read memory
`timescale 1ns / 1ps
module ssp_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8,
	parameter int AW = 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/ssp_alu.sv -----
// shared saturating add and compare unit
`timescale 1ns / 1ps
module ssp_alu (
	input  ssp_pkg::alu_req_t req,
	output ssp_pkg::alu_rsp_t rsp
);
	import ssp_pkg::*;

	logic [DIST_W:0] sum_w;
	logic [DIST_W-1:0] sat;

	assign sum_w = {1'b0, req.base} + {1'b0, req.addend};
	assign sat = (sum_w > {1'b0, DIST_MAX}) ? DIST_MAX : sum_w[DIST_W-1:0];

	always_comb begin
		rsp.sum = sat;
		rsp.lt = sat < req.bound;
	end
endmodule

// ----- sv/single_source_shortest_paths.sv -----
// add item: no result, the next item may follow at once
// run item: init, then per settled node a scan of the nodes in use and a read and decode of
// each stored edge (plus an update if it reaches an unsettled node), a last scan, then read,
// load and hold per result beat plus stalls; one add/compare unit and memory port are shared
// item stall stays high from run accept until the last result beat is taken
// reset (async, active low): edge store empty, no overflow, node count 64
`timescale 1ns / 1ps
`include "single_source_shortest_paths_defines.svh"
module single_source_shortest_paths #(
	parameter int MAX_NODES = ssp_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = ssp_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic opcode,
	input  logic [ssp_pkg::NODE_W-1:0] end_a,
	input  logic [ssp_pkg::NODE_W-1:0] end_b,
	input  logic [ssp_pkg::WEIGHT_IN_W-1:0] weight,
	output logic result_valid,
	input  logic result_stall,
	output logic [ssp_pkg::NODE_W-1:0] node_index,
	output logic [ssp_pkg::DIST_W-1:0] distance,
	output logic reachable,
	output logic edge_dropped,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ssp_pkg::NODE_W-1:0] cfg_data
);
	import ssp_pkg::*;

	localparam int SW = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
	localparam int EW = 2 * NODE_W + SW;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int NAW = $clog2(MAX_NODES + 1);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_INIT      = 4'd1;
	localparam logic [3:0] ST_SCAN      = 4'd2;
	localparam logic [3:0] ST_REL_RD    = 4'd3;
	localparam logic [3:0] ST_REL_DEC   = 4'd4;
	localparam logic [3:0] ST_REL_UPD   = 4'd5;
	localparam logic [3:0] ST_EMIT_RD   = 4'd6;
	localparam logic [3:0] ST_EMIT_LD   = 4'd7;
	localparam logic [3:0] ST_EMIT_HOLD = 4'd8;

	logic [3:0] state_q;
	logic [NODE_W-1:0] node_count_q;
	logic [ECW-1:0] edge_total_q;
	logic ovf_q;
	logic [NAW-1:0] n_q;
	logic [NAW-1:0] i_q;
	logic [NAW-1:0] u_q;
	logic [DIST_W-1:0] du_q;
	logic [ECW-1:0] e_q;
	logic [NAW-1:0] to_q;
	logic [SW-1:0] w_q;
	logic scan_busy_q;
	logic scan_vld_s1;
	logic [NAW-1:0] scan_idx_s1;
	logic [MAX_NODES:0] dvld_q;
	logic [MAX_NODES:0] fin_q;

	logic result_valid_q;
	logic [NODE_W-1:0] node_index_q;
	logic [DIST_W-1:0] distance_q;
	logic reachable_q;
	logic dropped_q;
	logic last_q;

	logic item_acc;
	logic edge_we;
	logic [EW-1:0] edge_wdata;
	logic [EW-1:0] edge_rd;
	logic [NODE_W-1:0] ea;
	logic [NODE_W-1:0] eb;
	logic [SW-1:0] ew;
	logic [NODE_W-1:0] n7;
	logic [NODE_W-1:0] u7;
	logic [NODE_W-1:0] to7;
	logic [NAW-1:0] to_idx;
	logic edge_hit;
	logic [NAW-1:0] n_eff;

	logic dist_we;
	logic [NAW-1:0] dist_waddr;
	logic [DIST_W-1:0] dist_wdata;
	logic [NAW-1:0] dist_raddr;
	logic [DIST_W-1:0] dist_rd_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic scan_take;
	logic rel_last;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc = item_valid && !item_stall;
	assign cfg_ready = 1'b1;

	assign result_valid = result_valid_q;
	assign node_index = node_index_q;
	assign distance = distance_q;
	assign reachable = reachable_q;
	assign edge_dropped = dropped_q;
	assign last = last_q;

	// node count clamp: zero means one, large values cap at the node limit
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NAW'(1);
		end else if (node_count_q > NODE_W'(MAX_NODES)) begin
			n_eff = NAW'(MAX_NODES);
		end else begin
			n_eff = node_count_q[NAW-1:0];
		end
	end

	assign edge_we = item_acc && (opcode == OP_ADD) && (edge_total_q < ECW'(MAX_EDGES));
	assign edge_wdata = {end_a, end_b, weight[SW-1:0]};

	ssp_ram #(
		.DEPTH(MAX_EDGES),
		.WIDTH(EW),
		.AW(EAW)
	) u_edge_ram (
		.clk(clk),
		.we(edge_we),
		.waddr(edge_total_q[EAW-1:0]),
		.wdata(edge_wdata),
		.raddr(e_q[EAW-1:0]),
		.rdata(edge_rd)
	);

	assign ea = edge_rd[EW-1 -: NODE_W];
	assign eb = edge_rd[SW+NODE_W-1 -: NODE_W];
	assign ew = edge_rd[SW-1:0];
	assign n7 = NODE_W'(n_q);
	assign u7 = NODE_W'(u_q);
	assign to7 = (ea == u7) ? eb : ea;
	assign to_idx = to7[NAW-1:0];
	assign edge_hit = (ea != '0) && (ea <= n7) && (eb != '0) && (eb <= n7)
		&& ((ea == u7) || (eb == u7));

	assign dist_raddr = (state_q == ST_REL_DEC) ? to_idx : i_q;

	always_comb begin
		dist_we = 1'b0;
		dist_waddr = to_q;
		dist_wdata = alu_rsp.sum;
		if (state_q == ST_INIT) begin
			dist_we = 1'b1;
			dist_waddr = NAW'(1);
			dist_wdata = '0;
		end else if (state_q == ST_REL_UPD) begin
			dist_we = !dvld_q[to_q] || alu_rsp.lt;
		end
	end

	ssp_ram #(
		.DEPTH(MAX_NODES + 1),
		.WIDTH(DIST_W),
		.AW(NAW)
	) u_dist_ram (
		.clk(clk),
		.we(dist_we),
		.waddr(dist_waddr),
		.wdata(dist_wdata),
		.raddr(dist_raddr),
		.rdata(dist_rd_q)
	);

	// scan: is the node under compare nearer than the best so far; relax: du + w vs stored
	always_comb begin
		if (state_q == ST_SCAN) begin
			alu_req.base = dist_rd_q;
			alu_req.addend = '0;
			alu_req.bound = du_q;
		end else begin
			alu_req.base = du_q;
			alu_req.addend = DIST_W'(w_q);
			alu_req.bound = dist_rd_q;
		end
	end

	ssp_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign scan_take = scan_vld_s1 && dvld_q[scan_idx_s1] && !fin_q[scan_idx_s1]
		&& ((u_q == '0) || alu_rsp.lt);
	assign rel_last = (e_q + ECW'(1)) == edge_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= NODE_COUNT_RST;
			edge_total_q <= '0;
			ovf_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
			u_q <= '0;
			e_q <= '0;
			to_q <= '0;
			w_q <= '0;
			scan_busy_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			dvld_q <= '0;
			fin_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (opcode == OP_RUN) begin
							n_q <= n_eff;
							state_q <= ST_INIT;
						end else if (!edge_we) begin
							ovf_q <= 1'b1;
						end else begin
							edge_total_q <= edge_total_q + ECW'(1);
						end
					end
				end
				ST_INIT: begin
					// only node one starts out reached
					dvld_q <= {{(MAX_NODES-1){1'b0}}, 2'b10};
					fin_q <= '0;
					i_q <= NAW'(1);
					u_q <= '0;
					scan_busy_q <= 1'b1;
					scan_vld_s1 <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// issue one node read a cycle, compare it in the cycle after
					if (scan_busy_q) begin
						scan_vld_s1 <= 1'b1;
						if (i_q == n_q) begin
							scan_busy_q <= 1'b0;
						end else begin
							i_q <= i_q + NAW'(1);
						end
					end else begin
						scan_vld_s1 <= 1'b0;
					end
					if (scan_take) begin
						u_q <= scan_idx_s1;
					end
					if (!scan_busy_q && !scan_vld_s1) begin
						if (u_q == '0) begin
							i_q <= NAW'(1);
							state_q <= ST_EMIT_RD;
						end else begin
							fin_q[u_q] <= 1'b1;
							e_q <= '0;
							if (edge_total_q == '0) begin
								i_q <= NAW'(1);
								u_q <= '0;
								scan_busy_q <= 1'b1;
							end else begin
								state_q <= ST_REL_RD;
							end
						end
					end
				end
				ST_REL_RD: begin
					state_q <= ST_REL_DEC;
				end
				ST_REL_DEC: begin
					to_q <= to_idx;
					w_q <= ew;
					if (edge_hit && !fin_q[to_idx]) begin
						state_q <= ST_REL_UPD;
					end else if (rel_last) begin
						i_q <= NAW'(1);
						u_q <= '0;
						scan_busy_q <= 1'b1;
						state_q <= ST_SCAN;
					end else begin
						e_q <= e_q + ECW'(1);
						state_q <= ST_REL_RD;
					end
				end
				ST_REL_UPD: begin
					if (dist_we) begin
						dvld_q[to_q] <= 1'b1;
					end
					if (rel_last) begin
						i_q <= NAW'(1);
						u_q <= '0;
						scan_busy_q <= 1'b1;
						state_q <= ST_SCAN;
					end else begin
						e_q <= e_q + ECW'(1);
						state_q <= ST_REL_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					result_valid_q <= 1'b1;
					state_q <= ST_EMIT_HOLD;
				end
				ST_EMIT_HOLD: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						if (last_q) begin
							edge_total_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + NAW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// best distance tracker and result beat payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && scan_take) begin
			du_q <= dist_rd_q;
		end
		if (state_q == ST_SCAN && scan_busy_q) begin
			scan_idx_s1 <= i_q;
		end
		if (state_q == ST_EMIT_LD) begin
			node_index_q <= NODE_W'(i_q);
			distance_q <= dvld_q[i_q] ? dist_rd_q : '0;
			reachable_q <= dvld_q[i_q];
			dropped_q <= ovf_q;
			last_q <= (i_q == n_q);
		end
	end

	`SSP_ASSERT_NOW(a_valid_in_hold, result_valid_q, state_q == ST_EMIT_HOLD,
		"result beat shown outside the emit hold state")
	`SSP_ASSERT_NOW(a_edge_total_max, 1'b1, edge_total_q <= ECW'(MAX_EDGES),
		"edge count beyond store depth")
	`SSP_ASSERT_NEXT(a_last_clears, result_valid && !result_stall && last,
		edge_total_q == '0 && !ovf_q && !item_stall,
		"edge store not emptied after last result beat")
	`SSP_ASSERT_NOW(a_scan_pick_open, state_q == ST_SCAN && u_q != '0,
		dvld_q[u_q] && !fin_q[u_q],
		"scan picked a node that is unreached or settled")
endmodule

// ----- verif/single_source_shortest_paths_tb.sv -----
// testbench for the single source shortest path block: edge loads, searches, node reports
`timescale 1ns / 1ps
module single_source_shortest_paths_tb;
	localparam int NODE_CAP = ssp_pkg::MAX_NODES_DEF;
	localparam int EDGE_CAP = ssp_pkg::MAX_EDGES_DEF;
	localparam int ITEM_TARGET = 460;
	localparam int HOLD_CYCLES = 400;
	localparam longint RUN_LIMIT_NS = 10_000_000;

	typedef struct packed {
		logic op;
		logic [ssp_pkg::NODE_W-1:0] a;
		logic [ssp_pkg::NODE_W-1:0] b;
		logic [ssp_pkg::WEIGHT_IN_W-1:0] w;
	} graph_cmd_t;

	typedef struct packed {
		logic [ssp_pkg::NODE_W-1:0] node;
		logic [ssp_pkg::DIST_W-1:0] distance;
		logic reachable;
		logic dropped;
		logic last_node;
	} node_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic opcode = ssp_pkg::OP_ADD;
	logic [ssp_pkg::NODE_W-1:0] end_a = '0;
	logic [ssp_pkg::NODE_W-1:0] end_b = '0;
	logic [ssp_pkg::WEIGHT_IN_W-1:0] weight = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [ssp_pkg::NODE_W-1:0] node_index;
	logic [ssp_pkg::DIST_W-1:0] distance;
	logic reachable;
	logic edge_dropped;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ssp_pkg::NODE_W-1:0] cfg_data = '0;

	// shadow of the block's graph state
	logic [ssp_pkg::NODE_W-1:0] graph_a [0:EDGE_CAP-1];
	logic [ssp_pkg::NODE_W-1:0] graph_b [0:EDGE_CAP-1];
	logic [ssp_pkg::WEIGHT_IN_W-1:0] graph_w [0:EDGE_CAP-1];
	int graph_edges = 0;
	bit graph_overflow = 1'b0;
	logic [ssp_pkg::NODE_W-1:0] node_count_q = ssp_pkg::NODE_COUNT_RST;

	graph_cmd_t queued_cmds[$];
	node_report_t expected_reports[$];
	int queued_total = 0;
	int fail_count = 0;

	graph_cmd_t cur_cmd;
	bit send_busy = 1'b0;
	int send_wait = 0;
	int send_idle_pct = 0;
	int recv_wait = 0;
	int recv_idle_pct = 0;
	bit hold_pending = 1'b0;
	int hold_left = 0;
	node_report_t want;

	single_source_shortest_paths dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.end_a(end_a),
		.end_b(end_b),
		.weight(weight),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.node_index(node_index),
		.distance(distance),
		.reachable(reachable),
		.edge_dropped(edge_dropped),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int nodes_used(input logic [ssp_pkg::NODE_W-1:0] count);
		if (count == 0) return 1;
		if (count > NODE_CAP) return NODE_CAP;
		return int'(count);
	endfunction

	function automatic int draw_gap(input int pct);
		if ($urandom_range(0, 99) < pct) return $urandom_range(1, 16);
		return 0;
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 25;
			default: return 75;
		endcase
	endfunction

	// linear-scan shortest path search from node one, queues one report per node in use
	task automatic solve_from_node_one();
		logic [ssp_pkg::DIST_W-1:0] best [1:NODE_CAP];
		bit known [1:NODE_CAP];
		bit done [1:NODE_CAP];
		logic [ssp_pkg::DIST_W:0] cand;
		node_report_t rep;
		int n;
		int u;
		int other;
		n = nodes_used(node_count_q);
		for (int i = 1; i <= NODE_CAP; i++) begin
			best[i] = '0;
			known[i] = 1'b0;
			done[i] = 1'b0;
		end
		known[1] = 1'b1;
		for (int step = 0; step < n; step++) begin
			u = 0;
			for (int i = 1; i <= n; i++) begin
				if (known[i] && !done[i] && (u == 0 || best[i] < best[u])) u = i;
			end
			if (u != 0) begin
				done[u] = 1'b1;
				for (int e = 0; e < graph_edges; e++) begin
					other = 0;
					if (graph_a[e] != 0 && graph_a[e] <= n && graph_b[e] != 0 && graph_b[e] <= n) begin
						if (graph_a[e] == u) other = int'(graph_b[e]);
						else if (graph_b[e] == u) other = int'(graph_a[e]);
					end
					if (other != 0 && !done[other]) begin
						cand = {1'b0, best[u]} + graph_w[e];
						if (cand > {1'b0, ssp_pkg::DIST_MAX}) cand = {1'b0, ssp_pkg::DIST_MAX};
						if (!known[other] || cand[ssp_pkg::DIST_W-1:0] < best[other]) begin
							best[other] = cand[ssp_pkg::DIST_W-1:0];
							known[other] = 1'b1;
						end
					end
				end
			end
		end
		for (int i = 1; i <= n; i++) begin
			rep.node = ssp_pkg::NODE_W'(i);
			rep.distance = known[i] ? best[i] : '0;
			rep.reachable = known[i];
			rep.dropped = graph_overflow;
			rep.last_node = (i == n);
			expected_reports = {expected_reports, rep};
		end
		graph_edges = 0;
		graph_overflow = 1'b0;
	endtask

	task automatic apply_graph_cmd(input graph_cmd_t c);
		if (c.op == ssp_pkg::OP_ADD) begin
			if (graph_edges < EDGE_CAP) begin
				graph_a[graph_edges] = c.a;
				graph_b[graph_edges] = c.b;
				graph_w[graph_edges] = c.w;
				graph_edges++;
			end else begin
				graph_overflow = 1'b1;
			end
		end else begin
			solve_from_node_one();
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			send_busy = item_valid;
			if (item_valid && !item_stall) begin
				apply_graph_cmd(cur_cmd);
				send_busy = 1'b0;
				send_wait = draw_gap(send_idle_pct);
			end
			if (!send_busy) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (queued_cmds.size() != 0) begin
					cur_cmd = queued_cmds.pop_front();
					send_busy = 1'b1;
					opcode <= cur_cmd.op;
					end_a <= cur_cmd.a;
					end_b <= cur_cmd.b;
					weight <= cur_cmd.w;
				end
			end
			item_valid <= send_busy;
		end
	end

	// report monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result beat with nothing expected: node_index %0d", node_index);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("node_index", 32'(want.node), 32'(node_index));
					check_field("distance", 32'(want.distance), 32'(distance));
					check_field("reachable", 32'(want.reachable), 32'(reachable));
					check_field("edge_dropped", 32'(want.dropped), 32'(edge_dropped));
					check_field("last", 32'(want.last_node), 32'(last));
				end
				recv_wait = draw_gap(recv_idle_pct);
			end
			// long hold-off so the block backs up and stalls the item side
			if (hold_pending && result_valid) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_node_count(input logic [ssp_pkg::NODE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_count_q = value;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (queued_cmds.size() != 0 || item_valid || expected_reports.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic queue_edge(input int a, input int b, input logic [15:0] w);
		graph_cmd_t c;
		c.op = ssp_pkg::OP_ADD;
		c.a = ssp_pkg::NODE_W'(a);
		c.b = ssp_pkg::NODE_W'(b);
		c.w = w;
		queued_cmds = {queued_cmds, c};
		queued_total++;
	endtask

	task automatic queue_run();
		graph_cmd_t c;
		c.op = ssp_pkg::OP_RUN;
		c.a = ssp_pkg::NODE_W'($urandom);
		c.b = ssp_pkg::NODE_W'($urandom);
		c.w = ssp_pkg::WEIGHT_IN_W'($urandom);
		queued_cmds = {queued_cmds, c};
		queued_total++;
	endtask

	function automatic logic [15:0] draw_weight();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// mostly in-range edges, some with a bad endpoint, some self loops
	task automatic queue_rand_edge(input int n);
		int bad;
		int good;
		int x;
		case ($urandom_range(0, 9))
			0: begin
				bad = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 127);
				good = $urandom_range(1, n);
				if ($urandom_range(0, 1)) queue_edge(bad, good, draw_weight());
				else queue_edge(good, bad, draw_weight());
			end
			1: begin
				x = $urandom_range(1, n);
				queue_edge(x, x, draw_weight());
			end
			default: queue_edge($urandom_range(1, n), $urandom_range(1, n), draw_weight());
		endcase
	endtask

	// spanning tree rooted at node one, endpoints in random order
	task automatic queue_tree(input int n);
		int p;
		for (int i = 2; i <= n; i++) begin
			p = $urandom_range(1, i - 1);
			if ($urandom_range(0, 1)) queue_edge(p, i, draw_weight());
			else queue_edge(i, p, draw_weight());
		end
	endtask

	function automatic logic [ssp_pkg::NODE_W-1:0] pick_node_count();
		case ($urandom_range(0, 19))
			0: return 7'd1;
			1: return 7'd0;
			2: return ssp_pkg::NODE_W'($urandom_range(65, 127));
			3: return ssp_pkg::NODE_W'($urandom_range(13, 64));
			default: return ssp_pkg::NODE_W'($urandom_range(2, 12));
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int runs;
		int extra;
		int tmp;
		int j;
		int chain_order [1:NODE_CAP-1];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// search at the reset node count with an empty store
		send_idle_pct = pick_idle();
		recv_idle_pct = pick_idle();
		queue_run();
		wait_idle();

		// five nodes: zero and max weights, reversed ends, self loop,
		// endpoints zero and above the node count, parallel edges
		write_node_count(7'd5);
		queue_edge(1, 2, 16'd0);
		queue_edge(2, 3, 16'hFFFF);
		queue_edge(3, 1, 16'd7);
		queue_edge(4, 4, 16'd1);
		queue_edge(0, 4, 16'd1);
		queue_edge(4, 127, 16'd1);
		queue_edge(6, 4, 16'd1);
		queue_edge(64, 5, 16'd2);
		queue_edge(2, 5, 16'd100);
		queue_edge(5, 2, 16'd50);
		queue_run();
		wait_idle();

		// smallest graph, then zero and oversized node counts
		write_node_count(7'd1);
		queue_edge(1, 1, 16'd5);
		queue_edge(1, 2, 16'd3);
		queue_run();
		wait_idle();
		write_node_count(7'd0);
		queue_run();
		wait_idle();
		write_node_count(7'd127);
		queue_edge(1, 64, 16'hFFFF);
		queue_edge(64, 63, 16'd1);
		queue_run();
		wait_idle();

		for (int phase = 0; queued_total < ITEM_TARGET; phase++) begin
			send_idle_pct = pick_idle();
			recv_idle_pct = pick_idle();
			if (phase == 1) begin
				// fill the store past its capacity, then an empty search
				n = $urandom_range(8, 20);
				write_node_count(ssp_pkg::NODE_W'(n));
				queue_tree(n);
				while (queued_cmds.size() < EDGE_CAP + 2) queue_rand_edge(n);
				queue_run();
				queue_run();
			end else if (phase == 4) begin
				// max weight chain over all nodes, shuffled
				write_node_count(7'd64);
				for (int i = 1; i < NODE_CAP; i++) chain_order[i] = i;
				for (int i = NODE_CAP - 1; i > 1; i--) begin
					j = $urandom_range(1, i);
					tmp = chain_order[i];
					chain_order[i] = chain_order[j];
					chain_order[j] = tmp;
				end
				for (int i = 1; i < NODE_CAP; i++) begin
					if ($urandom_range(0, 1))
						queue_edge(chain_order[i], chain_order[i] + 1, 16'hFFFF);
					else
						queue_edge(chain_order[i] + 1, chain_order[i], 16'hFFFF);
				end
				queue_run();
			end else begin
				write_node_count(pick_node_count());
				n = nodes_used(node_count_q);
				runs = $urandom_range(1, 3);
				if (phase == 0) begin
					hold_pending = 1'b1;
					runs = 2;
				end
				for (int r = 0; r < runs; r++) begin
					if (n <= 16 && $urandom_range(0, 3) != 0) queue_tree(n);
					extra = $urandom_range(0, 6);
					for (int k = 0; k < extra; k++) queue_rand_edge(n);
					queue_run();
				end
				// leftover edges carry over into the next node count
				if ($urandom_range(0, 3) == 0) begin
					extra = $urandom_range(1, 2);
					for (int k = 0; k < extra; k++) queue_rand_edge(n);
				end
			end
			wait_idle();
		end

		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("single_source_shortest_paths_tb: PASS");
		else
			$display("single_source_shortest_paths_tb: FAIL");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("single_source_shortest_paths_tb: FAIL");
		$finish;
	end
endmodule
